/* sv/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, muted while reset is asserted.
`define ASSERT_RST(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Clocked assertion that must also hold during reset.
`define ASSERT_CLK(name, prop, msg) \
	name: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* sv/prj_pkg.sv */
package prj_pkg;

	// configuration register reset values (unsigned Q16.8 pixels)
	localparam logic [23:0] FOCAL_X_RST  = 24'd128000;
	localparam logic [23:0] FOCAL_Y_RST  = 24'd128000;
	localparam logic [23:0] CENTER_X_RST = 24'd81920;
	localparam logic [23:0] CENTER_Y_RST = 24'd61440;

	// register indexes (paddr[3:2])
	localparam logic [1:0] REG_FOCAL_X  = 2'd0;
	localparam logic [1:0] REG_FOCAL_Y  = 2'd1;
	localparam logic [1:0] REG_CENTER_X = 2'd2;
	localparam logic [1:0] REG_CENTER_Y = 2'd3;

	// datapath widths
	localparam int NUM_PU_W = 74;   // f*|x| + z/2
	localparam int NUM_JD_W = 63;   // (f << 38) + z/2
	localparam int NUM_JZ_W = 112;  // (f*|x| << 38) + z^2/2
	localparam int DEN_Z_W  = 49;   // depth
	localparam int DEN_Z2_W = 98;   // depth squared
	localparam int QUO_W    = 31;   // quotient bits, one per divider stage
	localparam int SQ_W     = 50;   // radicand width
	localparam int SQ_STEPS = 25;   // root bits, one per square-root stage

	localparam int FRONT_STAGES = 7;
	localparam int MID_STAGES   = 4;
	localparam int LAT = FRONT_STAGES + QUO_W + MID_STAGES + SQ_STEPS + 1;

	localparam logic [23:0] ERR_MAX    = 24'hFFFFFF;
	localparam logic [23:0] PIX_BEHIND = 24'hFFFF00;
	localparam logic [23:0] PIX_MAX    = 24'h7FFFFF;
	localparam logic [23:0] PIX_MIN    = 24'h800000;
	localparam logic [31:0] JAC_MAX    = 32'h7FFFFFFF;
	localparam logic [31:0] JAC_MIN    = 32'h80000000;

	typedef struct packed {
		logic        behind;
		logic        x_neg;
		logic        x_pos;
		logic        y_neg;
		logic        y_pos;
		logic [23:0] obs_u;
		logic [23:0] obs_v;
	} side_t;

	typedef struct packed {
		side_t                side;
		logic [NUM_PU_W-1:0] num_pu;
		logic [NUM_PU_W-1:0] num_pv;
		logic [NUM_JD_W-1:0] num_jx;
		logic [NUM_JD_W-1:0] num_jy;
		logic [NUM_JZ_W-1:0] num_zx;
		logic [NUM_JZ_W-1:0] num_zy;
		logic [DEN_Z_W-1:0]  den_z;
		logic [DEN_Z2_W-1:0] den_z2;
	} front_t;

	typedef struct packed {
		logic        behind;
		logic        sat;
		logic [23:0] proj_u;
		logic [23:0] proj_v;
		logic [31:0] jac_u_x;
		logic [31:0] jac_u_z;
		logic [31:0] jac_v_y;
		logic [31:0] jac_v_z;
	} post_t;

	typedef struct packed {
		logic        behind;
		logic [23:0] proj_u;
		logic [23:0] proj_v;
		logic [23:0] reproj_error;
		logic [31:0] jac_u_x;
		logic [31:0] jac_u_z;
		logic [31:0] jac_v_y;
		logic [31:0] jac_v_z;
	} res_t;

endpackage

/* sv/prj_front.sv */
module prj_front (
	input  logic               clk,
	input  logic               en,
	input  logic [47:0]        rot_row0,
	input  logic [47:0]        rot_row1,
	input  logic [47:0]        rot_row2,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [23:0] obs_u,
	input  logic signed [23:0] obs_v,
	input  logic [23:0]        focal_x,
	input  logic [23:0]        focal_y,
	output prj_pkg::front_t    front
);
	import prj_pkg::*;

	logic [47:0]        rot_s1 [3];
	logic signed [32:0] dif_s1 [3];
	logic signed [48:0] prd_s2 [3][3];
	logic signed [50:0] xc_s3 [3];
	logic [47:0]        obs_s1, obs_s2, obs_s3, obs_s4, obs_s5, obs_s6;
	logic [4:0]         flg_s4, flg_s5, flg_s6;
	logic [48:0]        mx_s4, my_s4, z_s4, z_s5, z_s6;
	logic [48:0]        pxl_s5, pyl_s5, zlh_s5;
	logic [47:0]        pxh_s5, pyh_s5, zhh_s5;
	logic [49:0]        zll_s5;
	logic [72:0]        nx_s6, ny_s6;
	logic [97:0]        z2_s6;
	front_t             front_s7;
	logic signed [50:0] negx, negy;

	assign negx = -xc_s3[0];
	assign negy = -xc_s3[1];

	// s1: point minus translation
	always_ff @(posedge clk) begin
		if (en) begin
			rot_s1[0] <= rot_row0;
			rot_s1[1] <= rot_row1;
			rot_s1[2] <= rot_row2;
			dif_s1[0] <= 33'(point_x) - 33'(trans_x);
			dif_s1[1] <= 33'(point_y) - 33'(trans_y);
			dif_s1[2] <= 33'(point_z) - 33'(trans_z);
			obs_s1    <= {obs_v, obs_u};
		end
	end

	// s2: nine rotation products, s3: column sums (transposed rotation)
	always_ff @(posedge clk) begin
		if (en) begin
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					prd_s2[r][c] <= 49'($signed(rot_s1[r][16*c +: 16])) * 49'(dif_s1[r]);
				end
			end
			obs_s2 <= obs_s1;
			for (int c = 0; c < 3; c++) begin
				xc_s3[c] <= 51'(prd_s2[0][c]) + 51'(prd_s2[1][c]) + 51'(prd_s2[2][c]);
			end
			obs_s3 <= obs_s2;
		end
	end

	// s4: depth test, magnitudes
	always_ff @(posedge clk) begin
		if (en) begin
			mx_s4  <= xc_s3[0][50] ? negx[48:0] : xc_s3[0][48:0];
			my_s4  <= xc_s3[1][50] ? negy[48:0] : xc_s3[1][48:0];
			z_s4   <= xc_s3[2][48:0];
			flg_s4 <= {xc_s3[2][50] || (xc_s3[2] == '0),
				xc_s3[0][50], !xc_s3[0][50] && (xc_s3[0] != '0),
				xc_s3[1][50], !xc_s3[1][50] && (xc_s3[1] != '0)};
			obs_s4 <= obs_s3;
		end
	end

	// s5: partial products, s6: recombine
	always_ff @(posedge clk) begin
		if (en) begin
			pxl_s5 <= 49'(focal_x) * 49'(mx_s4[24:0]);
			pxh_s5 <= 48'(focal_x) * 48'(mx_s4[48:25]);
			pyl_s5 <= 49'(focal_y) * 49'(my_s4[24:0]);
			pyh_s5 <= 48'(focal_y) * 48'(my_s4[48:25]);
			zll_s5 <= 50'(z_s4[24:0]) * 50'(z_s4[24:0]);
			zlh_s5 <= 49'(z_s4[24:0]) * 49'(z_s4[48:25]);
			zhh_s5 <= 48'(z_s4[48:25]) * 48'(z_s4[48:25]);
			z_s5   <= z_s4;
			flg_s5 <= flg_s4;
			obs_s5 <= obs_s4;

			nx_s6  <= 73'(pxl_s5) + (73'(pxh_s5) << 25);
			ny_s6  <= 73'(pyl_s5) + (73'(pyh_s5) << 25);
			z2_s6  <= 98'(zll_s5) + (98'(zlh_s5) << 26) + (98'(zhh_s5) << 50);
			z_s6   <= z_s5;
			flg_s6 <= flg_s5;
			obs_s6 <= obs_s5;
		end
	end

	// s7: add half the divisor for round-to-nearest
	always_ff @(posedge clk) begin
		if (en) begin
			front_s7.side.behind <= flg_s6[4];
			front_s7.side.x_neg  <= flg_s6[3];
			front_s7.side.x_pos  <= flg_s6[2];
			front_s7.side.y_neg  <= flg_s6[1];
			front_s7.side.y_pos  <= flg_s6[0];
			front_s7.side.obs_u  <= obs_s6[23:0];
			front_s7.side.obs_v  <= obs_s6[47:24];
			front_s7.num_pu <= NUM_PU_W'(nx_s6) + NUM_PU_W'(z_s6 >> 1);
			front_s7.num_pv <= NUM_PU_W'(ny_s6) + NUM_PU_W'(z_s6 >> 1);
			front_s7.num_jx <= (NUM_JD_W'(focal_x) << 38) + NUM_JD_W'(z_s6 >> 1);
			front_s7.num_jy <= (NUM_JD_W'(focal_y) << 38) + NUM_JD_W'(z_s6 >> 1);
			front_s7.num_zx <= (NUM_JZ_W'(nx_s6) << 38) + NUM_JZ_W'(z2_s6 >> 1);
			front_s7.num_zy <= (NUM_JZ_W'(ny_s6) << 38) + NUM_JZ_W'(z2_s6 >> 1);
			front_s7.den_z  <= z_s6;
			front_s7.den_z2 <= z2_s6;
		end
	end

	assign front = front_s7;

endmodule

/* sv/prj_div.sv */
module prj_div #(
	parameter int NW = prj_pkg::NUM_PU_W,
	parameter int DW = prj_pkg::DEN_Z_W,
	parameter int QW = prj_pkg::QUO_W
) (
	input  logic          clk,
	input  logic          en,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quo,
	output logic          ovf
);
	localparam int RW = (NW > DW + QW) ? NW : DW + QW;

	logic [RW-1:0] rem_s [QW];
	logic [DW-1:0] den_s [QW];
	logic [QW-1:0] quo_s [QW];
	logic          ovf_s [QW];

	logic [RW-1:0] rin [QW];
	logic [DW-1:0] din [QW];
	logic [QW-1:0] qin [QW];
	logic          oin [QW];
	logic [RW:0]   dif [QW];

	// one quotient bit per stage, most significant first
	always_comb begin
		for (int k = 0; k < QW; k++) begin
			if (k == 0) begin
				rin[k] = RW'(num);
				din[k] = den;
				qin[k] = '0;
				oin[k] = RW'(num) >= (RW'(den) << QW);
			end else begin
				rin[k] = rem_s[k-1];
				din[k] = den_s[k-1];
				qin[k] = quo_s[k-1];
				oin[k] = ovf_s[k-1];
			end
			dif[k] = {1'b0, rin[k]} - ({1'b0, RW'(din[k])} << (QW - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < QW; k++) begin
				rem_s[k] <= dif[k][RW] ? rin[k] : dif[k][RW-1:0];
				quo_s[k] <= qin[k] | (QW'(!dif[k][RW]) << (QW - 1 - k));
				den_s[k] <= din[k];
				ovf_s[k] <= oin[k];
			end
		end
	end

	assign quo = quo_s[QW-1];
	assign ovf = ovf_s[QW-1];

endmodule

/* sv/prj_sqrt.sv */
module prj_sqrt (
	input  logic                     clk,
	input  logic                     en,
	input  logic [prj_pkg::SQ_W-1:0] rad,
	output logic [prj_pkg::SQ_W-1:0] root,
	output logic [prj_pkg::SQ_W-1:0] rmd
);
	import prj_pkg::*;

	logic [SQ_W-1:0] rem_s [SQ_STEPS];
	logic [SQ_W-1:0] rt_s  [SQ_STEPS];
	logic [SQ_W-1:0] sin   [SQ_STEPS];
	logic [SQ_W-1:0] rin   [SQ_STEPS];
	logic [SQ_W-1:0] trial [SQ_STEPS];
	logic [SQ_W-1:0] bitv  [SQ_STEPS];

	// digit-by-digit root, one result bit per stage
	always_comb begin
		for (int k = 0; k < SQ_STEPS; k++) begin
			sin[k]   = (k == 0) ? rad : rem_s[k-1];
			rin[k]   = (k == 0) ? '0 : rt_s[k-1];
			bitv[k]  = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
			trial[k] = rin[k] + bitv[k];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < SQ_STEPS; k++) begin
				if (sin[k] >= trial[k]) begin
					rem_s[k] <= sin[k] - trial[k];
					rt_s[k]  <= (rin[k] >> 1) + bitv[k];
				end else begin
					rem_s[k] <= sin[k];
					rt_s[k]  <= rin[k] >> 1;
				end
			end
		end
	end

	assign root = rt_s[SQ_STEPS-1];
	assign rmd  = rem_s[SQ_STEPS-1];

endmodule

/* sv/pinhole_reprojection_error_unit.sv */
// Pinhole reprojection error unit: takes one request per cycle (world point, camera pose
// with Q2.14 rotation rows and Q16.16 translation, observed Q16.8 pixel) and returns the
// projected pixel, the rounded Euclidean reprojection error and the four nonzero point
// Jacobian entries. Each request passes through 7 front stages, the 31-stage restoring
// dividers (one quotient bit per stage, six in parallel) and the 25-stage square-root
// pipeline, with 5 stages of projection, saturation and squaring around them.
// Throughput is one request per clock. A two-entry output buffer absorbs a stall, so
// the input keeps taking requests while a finished result waits; req_stall rises only
// once both entries are full. Configuration (focal lengths and principal point, 24-bit
// unsigned Q16.8) is written over the APB port at byte addresses 0, 4, 8 and 12 and must
// only be changed while no request is in flight. A point with zero or negative depth
// reports behind_camera, pixel -1.0, error all ones and zero Jacobian.
`include "assert_macros.svh"

module pinhole_reprojection_error_unit (
	input  logic               clk,
	input  logic               arst_n,
	// APB configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [3:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	// request channel
	input  logic               req_valid,
	output logic               req_stall,
	input  logic [47:0]        rot_row0,
	input  logic [47:0]        rot_row1,
	input  logic [47:0]        rot_row2,
	input  logic signed [31:0] trans_x,
	input  logic signed [31:0] trans_y,
	input  logic signed [31:0] trans_z,
	input  logic signed [31:0] point_x,
	input  logic signed [31:0] point_y,
	input  logic signed [31:0] point_z,
	input  logic signed [23:0] obs_u,
	input  logic signed [23:0] obs_v,
	// result channel
	output logic               res_valid,
	input  logic               res_stall,
	output logic               behind_camera,
	output logic signed [23:0] proj_u,
	output logic signed [23:0] proj_v,
	output logic [23:0]        reproj_error,
	output logic signed [31:0] jac_u_x,
	output logic signed [31:0] jac_u_z,
	output logic signed [31:0] jac_v_y,
	output logic signed [31:0] jac_v_z
);
	import prj_pkg::*;

	// configuration registers
	logic [23:0] focal_x_q, focal_y_q, center_x_q, center_y_q;

	// pipeline control
	logic           en;
	logic [LAT-1:0] vld_s;

	front_t            front;
	side_t             side_s [QUO_W];
	logic [QUO_W-1:0]  q_pu, q_pv, q_jx, q_jy, q_zx, q_zy;
	logic              o_pu, o_pv, o_jx, o_jy, o_zx, o_zy;

	post_t       post_c, post_s39, post_s40, post_s41, post_s42;
	post_t       post_s [SQ_STEPS];
	logic [47:0] obs_s39;
	logic [24:0] pu_r, pv_r;
	logic signed [24:0] du_c, dv_c;
	logic [24:0] mdu_s40, mdv_s40;
	logic [49:0] squ_s41, sqv_s41;
	logic [SQ_W-1:0] ssum_s42, root, rmd, rnd;
	res_t        res_s68;

	// output buffer
	res_t out_q, skid_q;
	logic out_vld_q, skid_vld_q, take;

	// ---------------------------------------------------------------- APB
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			focal_x_q  <= FOCAL_X_RST;
			focal_y_q  <= FOCAL_Y_RST;
			center_x_q <= CENTER_X_RST;
			center_y_q <= CENTER_Y_RST;
		end else if (psel && penable && pwrite) begin
			unique case (paddr[3:2])
				REG_FOCAL_X:  focal_x_q  <= pwdata[23:0];
				REG_FOCAL_Y:  focal_y_q  <= pwdata[23:0];
				REG_CENTER_X: center_x_q <= pwdata[23:0];
				REG_CENTER_Y: center_y_q <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			REG_FOCAL_X:  prdata = {8'd0, focal_x_q};
			REG_FOCAL_Y:  prdata = {8'd0, focal_y_q};
			REG_CENTER_X: prdata = {8'd0, center_x_q};
			REG_CENTER_Y: prdata = {8'd0, center_y_q};
			default:      prdata = '0;
		endcase
	end

	// ---------------------------------------------------------------- control
	// The whole pipeline advances together; hold it only when the skid entry is full.
	assign en        = !skid_vld_q;
	assign req_stall = skid_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[LAT-2:0], req_valid};
		end
	end

	// ---------------------------------------------------------------- s1..s7
	prj_front u_front (
		.clk, .en,
		.rot_row0, .rot_row1, .rot_row2,
		.trans_x, .trans_y, .trans_z,
		.point_x, .point_y, .point_z,
		.obs_u, .obs_v,
		.focal_x(focal_x_q), .focal_y(focal_y_q),
		.front
	);

	// ---------------------------------------------------------------- s8..s38
	// Six dividers run side by side; the sign and depth flags ride along.
	prj_div #(.NW(NUM_PU_W), .DW(DEN_Z_W), .QW(QUO_W)) u_div_pu (
		.clk, .en, .num(front.num_pu), .den(front.den_z), .quo(q_pu), .ovf(o_pu));
	prj_div #(.NW(NUM_PU_W), .DW(DEN_Z_W), .QW(QUO_W)) u_div_pv (
		.clk, .en, .num(front.num_pv), .den(front.den_z), .quo(q_pv), .ovf(o_pv));
	prj_div #(.NW(NUM_JD_W), .DW(DEN_Z_W), .QW(QUO_W)) u_div_jx (
		.clk, .en, .num(front.num_jx), .den(front.den_z), .quo(q_jx), .ovf(o_jx));
	prj_div #(.NW(NUM_JD_W), .DW(DEN_Z_W), .QW(QUO_W)) u_div_jy (
		.clk, .en, .num(front.num_jy), .den(front.den_z), .quo(q_jy), .ovf(o_jy));
	prj_div #(.NW(NUM_JZ_W), .DW(DEN_Z2_W), .QW(QUO_W)) u_div_zx (
		.clk, .en, .num(front.num_zx), .den(front.den_z2), .quo(q_zx), .ovf(o_zx));
	prj_div #(.NW(NUM_JZ_W), .DW(DEN_Z2_W), .QW(QUO_W)) u_div_zy (
		.clk, .en, .num(front.num_zy), .den(front.den_z2), .quo(q_zy), .ovf(o_zy));

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= front.side;
			for (int k = 1; k < QUO_W; k++) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- s39
	// Apply the sign, add the principal point and saturate to 24 bits.
	// Returns {saturated, pixel}.
	function automatic logic [24:0] proj_axis(input logic ovf, input logic neg,
		input logic [QUO_W-1:0] q, input logic [23:0] ctr);
		logic signed [33:0] p;
		logic [24:0] r;
		p = 34'(q);
		if (neg) p = -p;
		p = p + 34'(ctr);
		if (ovf) r = {1'b1, neg ? PIX_MIN : PIX_MAX};
		else if (p > 34'sd8388607) r = {1'b1, PIX_MAX};
		else if (p < -34'sd8388608) r = {1'b1, PIX_MIN};
		else r = {1'b0, p[23:0]};
		return r;
	endfunction

	function automatic logic [31:0] jac_diag(input logic ovf, input logic [QUO_W-1:0] q);
		return ovf ? JAC_MAX : 32'(q);
	endfunction

	// Sign flips for a positive coordinate; that side saturates one further (to JAC_MIN).
	function automatic logic [31:0] jac_depth(input logic ovf, input logic pos,
		input logic [QUO_W-1:0] q);
		logic [31:0] r;
		if (pos) r = ovf ? JAC_MIN : -32'(q);
		else r = ovf ? JAC_MAX : 32'(q);
		return r;
	endfunction

	assign pu_r = proj_axis(o_pu, side_s[QUO_W-1].x_neg, q_pu, center_x_q);
	assign pv_r = proj_axis(o_pv, side_s[QUO_W-1].y_neg, q_pv, center_y_q);

	always_comb begin
		post_c.behind = side_s[QUO_W-1].behind;
		if (side_s[QUO_W-1].behind) begin
			// point at or behind the camera: fixed fill values
			post_c.sat     = 1'b1;
			post_c.proj_u  = PIX_BEHIND;
			post_c.proj_v  = PIX_BEHIND;
			post_c.jac_u_x = '0;
			post_c.jac_u_z = '0;
			post_c.jac_v_y = '0;
			post_c.jac_v_z = '0;
		end else begin
			post_c.sat     = pu_r[24] || pv_r[24];
			post_c.proj_u  = pu_r[23:0];
			post_c.proj_v  = pv_r[23:0];
			post_c.jac_u_x = jac_diag(o_jx, q_jx);
			post_c.jac_u_z = jac_depth(o_zx, side_s[QUO_W-1].x_pos, q_zx);
			post_c.jac_v_y = jac_diag(o_jy, q_jy);
			post_c.jac_v_z = jac_depth(o_zy, side_s[QUO_W-1].y_pos, q_zy);
		end
	end

	// ---------------------------------------------------------------- s39..s42
	assign du_c = $signed({post_s39.proj_u[23], post_s39.proj_u})
		- $signed({obs_s39[23], obs_s39[23:0]});
	assign dv_c = $signed({post_s39.proj_v[23], post_s39.proj_v})
		- $signed({obs_s39[47], obs_s39[47:24]});

	always_ff @(posedge clk) begin
		if (en) begin
			post_s39 <= post_c;
			obs_s39  <= {side_s[QUO_W-1].obs_v, side_s[QUO_W-1].obs_u};

			post_s40 <= post_s39;
			mdu_s40  <= du_c[24] ? 25'(-du_c) : 25'(du_c);
			mdv_s40  <= dv_c[24] ? 25'(-dv_c) : 25'(dv_c);

			post_s41 <= post_s40;
			squ_s41  <= 50'(mdu_s40) * 50'(mdu_s40);
			sqv_s41  <= 50'(mdv_s40) * 50'(mdv_s40);

			post_s42 <= post_s41;
			ssum_s42 <= SQ_W'(squ_s41) + SQ_W'(sqv_s41);
		end
	end

	// ---------------------------------------------------------------- s43..s67
	prj_sqrt u_sqrt (.clk, .en, .rad(ssum_s42), .root, .rmd);

	always_ff @(posedge clk) begin
		if (en) begin
			post_s[0] <= post_s42;
			for (int k = 1; k < SQ_STEPS; k++) begin
				post_s[k] <= post_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------- s68
	// Round the root up when the remainder exceeds it, then cap at all ones.
	assign rnd = (rmd > root) ? root + SQ_W'(1) : root;

	always_ff @(posedge clk) begin
		if (en) begin
			res_s68.behind  <= post_s[SQ_STEPS-1].behind;
			res_s68.proj_u  <= post_s[SQ_STEPS-1].proj_u;
			res_s68.proj_v  <= post_s[SQ_STEPS-1].proj_v;
			res_s68.jac_u_x <= post_s[SQ_STEPS-1].jac_u_x;
			res_s68.jac_u_z <= post_s[SQ_STEPS-1].jac_u_z;
			res_s68.jac_v_y <= post_s[SQ_STEPS-1].jac_v_y;
			res_s68.jac_v_z <= post_s[SQ_STEPS-1].jac_v_z;
			if (post_s[SQ_STEPS-1].sat || rnd > SQ_W'(ERR_MAX)) res_s68.reproj_error <= ERR_MAX;
			else res_s68.reproj_error <= rnd[23:0];
		end
	end

	// ---------------------------------------------------------------- output buffer
	// Result register plus one skid entry; the pipeline holds only when both are full.
	assign take = out_vld_q && !res_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || take) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_s[LAT-1];
			end
		end else if (vld_s[LAT-1] && en) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || take) begin
			out_q <= skid_vld_q ? skid_q : res_s68;
		end else if (en) begin
			skid_q <= res_s68;
		end
	end

	assign res_valid     = out_vld_q;
	assign behind_camera = out_q.behind;
	assign proj_u        = $signed(out_q.proj_u);
	assign proj_v        = $signed(out_q.proj_v);
	assign reproj_error  = out_q.reproj_error;
	assign jac_u_x       = $signed(out_q.jac_u_x);
	assign jac_u_z       = $signed(out_q.jac_u_z);
	assign jac_v_y       = $signed(out_q.jac_v_y);
	assign jac_v_z       = $signed(out_q.jac_v_z);

	// ---------------------------------------------------------------- assertions
	`ASSERT_CLK(a_pready_high, pready, "pready dropped")
	`ASSERT_RST(a_skid_needs_out, !skid_vld_q || out_vld_q, "skid entry full while result register empty")
	`ASSERT_RST(a_skid_fills, (out_vld_q && res_stall && vld_s[LAT-1] && !skid_vld_q) |=> skid_vld_q, "stalled result lost")
	`ASSERT_RST(a_behind_fill, (out_vld_q && behind_camera) |-> (reproj_error == ERR_MAX && proj_u == PIX_BEHIND && jac_u_x == 0), "behind-camera fill values wrong")
	`ASSERT_RST(a_diag_nonneg, (out_vld_q && !behind_camera) |-> (!jac_u_x[31] && !jac_v_y[31]), "focal over depth negative")

endmodule
